>>> hw/rtl/mcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_pkg
// Shared types and constants of the multiset combination generator.
// ----------------------------------------------------------------------------
package mcg_pkg;

   localparam int MAX_VALUES_DEF = 8;
   localparam int MAX_LENGTH_DEF = 8;
   localparam int NUM_ELEMS      = 8;
   localparam int ELEM_IDX_W     = 3;
   localparam int VALUE_W        = 16;
   localparam int CMD_W          = 2;
   localparam int LEN_W          = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_NEXT  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_GATHER,
      ST_SEARCH,
      ST_FILL,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic [NUM_ELEMS-1:0][VALUE_W-1:0] elem;
      logic                              is_final;
      logic                              status;
   } result_type;

endpackage

>>> hw/rtl/mcg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_req_if / mcg_rsp_if
// Valid/ready channels for command transactions and sequence results.
// ----------------------------------------------------------------------------
interface mcg_req_if;
   import mcg_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface mcg_rsp_if;
   import mcg_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] elem_0;
   logic [VALUE_W-1:0] elem_1;
   logic [VALUE_W-1:0] elem_2;
   logic [VALUE_W-1:0] elem_3;
   logic [VALUE_W-1:0] elem_4;
   logic [VALUE_W-1:0] elem_5;
   logic [VALUE_W-1:0] elem_6;
   logic [VALUE_W-1:0] elem_7;
   logic               is_final;
   logic               status;

   modport source (output valid, output elem_0, output elem_1, output elem_2,
                   output elem_3, output elem_4, output elem_5, output elem_6,
                   output elem_7, output is_final, output status, input ready);
   modport sink   (input valid, input elem_0, input elem_1, input elem_2,
                   input elem_3, input elem_4, input elem_5, input elem_6,
                   input elem_7, input is_final, input status, output ready);
endinterface

>>> hw/rtl/mcg_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_store
// Sorted value register file: one write port, one read port.
// ----------------------------------------------------------------------------
module mcg_store #(
   parameter int DEPTH  = mcg_pkg::MAX_VALUES_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [mcg_pkg::VALUE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [mcg_pkg::VALUE_W-1:0] rd_data
);
   import mcg_pkg::*;

   logic [VALUE_W-1:0] values_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         values_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = values_ff[rd_addr];

endmodule

>>> hw/rtl/mcg_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcg_engine
// Sequencer around one shared comparator: sorted insert, index gather,
// rightmost-advance search and fill of the position vector.
// ----------------------------------------------------------------------------
module mcg_engine #(
   parameter int MAX_VALUES = mcg_pkg::MAX_VALUES_DEF,
   parameter int MAX_LENGTH = mcg_pkg::MAX_LENGTH_DEF,
   parameter int IDX_W      = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [mcg_pkg::CMD_W-1:0]   req_command,
   input  logic [mcg_pkg::VALUE_W-1:0] req_value,
   input  logic                        cfg_restart,
   input  logic [mcg_pkg::LEN_W-1:0]   eff_len,
   output logic                        store_wr_en,
   output logic [IDX_W-1:0]            store_wr_addr,
   output logic [mcg_pkg::VALUE_W-1:0] store_wr_data,
   output logic [IDX_W-1:0]            store_rd_addr,
   input  logic [mcg_pkg::VALUE_W-1:0] store_rd_data,
   output logic                        res_valid,
   input  logic                        res_take,
   output mcg_pkg::result_type         res
);
   import mcg_pkg::*;

   localparam int CNT_W = $clog2(MAX_VALUES + 1);
   localparam int KW    = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   pos_ff [MAX_LENGTH];
   logic [IDX_W-1:0]   pos_in [MAX_LENGTH];
   logic               exh_ff, exh_in;
   logic [KW-1:0]      k_ff, k_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [IDX_W-1:0]   nv_ff, nv_in;
   result_type         res_ff, res_in;

   logic [VALUE_W-1:0] cmp_a;
   logic [VALUE_W-1:0] cmp_b;
   logic               cmp_gt;
   logic [IDX_W-1:0]   cur_pos;
   logic [KW-1:0]      last_pos;

   assign cmp_gt   = cmp_a > cmp_b;
   assign cur_pos  = pos_ff[k_ff];
   assign last_pos = KW'(eff_len - 1'b1);
   assign res      = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         exh_ff   <= 1'b0;
         for (int i = 0; i < MAX_LENGTH; i++) begin
            pos_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         exh_ff   <= exh_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      ptr_ff <= ptr_in;
      val_ff <= val_in;
      nv_ff  <= nv_in;
      res_ff <= res_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      exh_in        = exh_ff;
      k_in          = k_ff;
      ptr_in        = ptr_ff;
      val_in        = val_ff;
      nv_in         = nv_ff;
      res_in        = res_ff;
      store_wr_en   = 1'b0;
      store_wr_addr = IDX_W'(ptr_ff);
      store_wr_data = val_ff;
      store_rd_addr = '0;
      cmp_a         = '0;
      cmp_b         = '0;
      req_ready     = 1'b0;
      res_valid     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_command)
                  CMD_CLEAR: begin
                     count_in = '0;
                     exh_in   = 1'b0;
                     pos_in   = '{default: '0};
                  end
                  CMD_LOAD: begin
                     exh_in = 1'b0;
                     pos_in = '{default: '0};
                     if (count_ff != CNT_W'(MAX_VALUES)) begin
                        val_in   = req_value;
                        ptr_in   = count_ff;
                        state_in = ST_INSERT;
                     end
                  end
                  CMD_NEXT: begin
                     res_in = '0;
                     if (count_ff == '0 || exh_ff) begin
                        res_in.status = 1'b1;
                        state_in      = ST_OUTPUT;
                     end else begin
                        k_in     = '0;
                        state_in = ST_GATHER;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INSERT: begin
            store_rd_addr = IDX_W'(ptr_ff - 1'b1);
            cmp_a         = store_rd_data;
            cmp_b         = val_ff;
            store_wr_en   = 1'b1;
            if (ptr_ff != '0 && cmp_gt) begin
               store_wr_data = store_rd_data;
               ptr_in        = ptr_ff - 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_GATHER: begin
            cmp_a         = VALUE_W'(count_ff);
            cmp_b         = VALUE_W'(cur_pos);
            store_rd_addr = cmp_gt ? cur_pos : IDX_W'(count_ff - 1'b1);
            res_in.elem[ELEM_IDX_W'(k_ff)] = store_rd_data;
            if (k_ff == last_pos) begin
               state_in = ST_SEARCH;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_SEARCH: begin
            cmp_a = VALUE_W'(count_ff);
            cmp_b = VALUE_W'(cur_pos) + VALUE_W'(1);
            if (cmp_gt) begin
               nv_in    = cur_pos + 1'b1;
               state_in = ST_FILL;
            end else if (k_ff == '0) begin
               exh_in          = 1'b1;
               res_in.is_final = 1'b1;
               state_in        = ST_OUTPUT;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         ST_FILL: begin
            pos_in[k_ff] = nv_ff;
            if (k_ff == last_pos) begin
               state_in = ST_OUTPUT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_OUTPUT: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_restart) begin
         pos_in = '{default: '0};
         exh_in = 1'b0;
      end
   end

endmodule

>>> hw/rtl/multiset_combination_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiset_combination_generator
// Sorted multiset store with lexicographic combination-with-repetition output.
//
// req_chan carries command transactions: clear the store, load a value
// (inserted in ascending order after equal values, dropped when the store is
// full) or request the next sequence. Each next request returns one rsp_chan
// transaction; clear and load return nothing. csr_wr_en/csr_wr_data set the
// sequence length, which the user writes only while the block is idle (not
// enforced by the block); a write, a clear or a load restarts the enumeration.
// Each transaction runs step by step, set by the single comparator and the
// single store read port:
//   clear: the accept step alone. load: accept, one shift per cycle for each
//   larger stored value, then the write. next: gather, search back, fill and
//   hand over; only the accept and the hand-over when the store is empty or exhausted.
// req_chan.ready is high only between transactions. A result sits in an
// output register, so the next transaction is accepted while rsp_chan stalls;
// a further result waits inside until that register frees up.
// Reset empties the store, sets the length to 1 and drops any pending result.
// ----------------------------------------------------------------------------
module multiset_combination_generator #(
   parameter int MAX_VALUES = mcg_pkg::MAX_VALUES_DEF,
   parameter int MAX_LENGTH = mcg_pkg::MAX_LENGTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   mcg_req_if.sink                   req_chan,
   mcg_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [mcg_pkg::LEN_W-1:0] csr_wr_data
);
   import mcg_pkg::*;

   localparam int IDX_W = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;

   logic [LEN_W-1:0]   seq_len_ff, seq_len_in;
   logic [LEN_W-1:0]   eff_len;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_data_ff, rsp_data_in;

   logic               store_wr_en;
   logic [IDX_W-1:0]   store_wr_addr;
   logic [VALUE_W-1:0] store_wr_data;
   logic [IDX_W-1:0]   store_rd_addr;
   logic [VALUE_W-1:0] store_rd_data;
   logic               res_valid;
   logic               res_take;
   result_type         res;

   always_comb begin
      if (seq_len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (seq_len_ff > LEN_W'(MAX_LENGTH)) begin
         eff_len = LEN_W'(MAX_LENGTH);
      end else begin
         eff_len = seq_len_ff;
      end
   end

   assign seq_len_in   = csr_wr_en ? csr_wr_data : seq_len_ff;
   assign res_take     = res_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_valid_in = res_take ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = res_take ? res : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff   <= LEN_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_len_ff   <= seq_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   mcg_store #(
      .DEPTH  (MAX_VALUES),
      .ADDR_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   mcg_engine #(
      .MAX_VALUES (MAX_VALUES),
      .MAX_LENGTH (MAX_LENGTH),
      .IDX_W      (IDX_W)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_command   (req_chan.command),
      .req_value     (req_chan.value),
      .cfg_restart   (csr_wr_en),
      .eff_len       (eff_len),
      .store_wr_en   (store_wr_en),
      .store_wr_addr (store_wr_addr),
      .store_wr_data (store_wr_data),
      .store_rd_addr (store_rd_addr),
      .store_rd_data (store_rd_data),
      .res_valid     (res_valid),
      .res_take      (res_take),
      .res           (res)
   );

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.elem_0   = rsp_data_ff.elem[0];
   assign rsp_chan.elem_1   = rsp_data_ff.elem[1];
   assign rsp_chan.elem_2   = rsp_data_ff.elem[2];
   assign rsp_chan.elem_3   = rsp_data_ff.elem[3];
   assign rsp_chan.elem_4   = rsp_data_ff.elem[4];
   assign rsp_chan.elem_5   = rsp_data_ff.elem[5];
   assign rsp_chan.elem_6   = rsp_data_ff.elem[6];
   assign rsp_chan.elem_7   = rsp_data_ff.elem[7];
   assign rsp_chan.is_final = rsp_data_ff.is_final;
   assign rsp_chan.status   = rsp_data_ff.status;

endmodule

>>> tb/multiset_combination_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiset_combination_generator_tb
// Self-checking testbench for the multiset combination generator. A queue of
// clear/load/next commands, with some of the unused code, feeds a valid/ready
// driver. A clocked monitor checks each sequence result against a cycle-free
// predictor of the sorted store and the lexicographic index enumeration. The run
// covers a directed opener and random phases over several sequence lengths.
// The phases take turns at four mixes of sender gaps and receiver stalls; one
// phase holds the result channel off long enough to back the block up.
// ----------------------------------------------------------------------------
module multiset_combination_generator_tb;
   import mcg_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int NUM_PHASES     = 8;
   localparam int ITEMS_PER_PHASE = 225;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [VALUE_W-1:0] value;
   } cmd_item_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [LEN_W-1:0] csr_wr_data;

   mcg_req_if req_bus ();
   mcg_rsp_if rsp_bus ();

   multiset_combination_generator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state
   logic [VALUE_W-1:0]    stored_vals [MAX_VALUES_DEF];
   int                    stored_cnt = 0;
   logic [ELEM_IDX_W-1:0] slot_idx [MAX_LENGTH_DEF];
   bit                    enum_done = 1'b0;
   logic [LEN_W-1:0]      seq_len_reg = 4'd1;

   cmd_item_type pending_cmds [$];
   result_type   expected_seqs [$];

   int queued_total  = 0;
   int useful_total  = 0;
   int sent_count    = 0;
   int checked_count = 0;
   int final_count   = 0;
   int no_seq_count  = 0;
   int dropped_loads = 0;
   int err_count     = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;
   logic hold_kick;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void restart_enum();
      foreach (slot_idx[k]) slot_idx[k] = '0;
      enum_done = 1'b0;
   endfunction

   function automatic void push_cmd(input logic [CMD_W-1:0] cmd,
                                    input logic [VALUE_W-1:0] val);
      cmd_item_type it;
      it.command = cmd;
      it.value   = val;
      pending_cmds = {pending_cmds, it};
      queued_total++;
      if (cmd != CMD_UNUSED) useful_total++;
   endfunction

   function automatic void apply_command(input logic [CMD_W-1:0] cmd,
                                         input logic [VALUE_W-1:0] val);
      result_type res;
      int len, p, k, slot;
      logic [ELEM_IDX_W-1:0] nv;
      res = '0;
      case (cmd)
         CMD_CLEAR: begin
            stored_cnt = 0;
            restart_enum();
         end
         CMD_LOAD: begin
            if (stored_cnt >= MAX_VALUES_DEF) begin
               dropped_loads++;
            end else begin
               slot = stored_cnt;
               while (slot > 0 && stored_vals[slot-1] > val) begin
                  stored_vals[slot] = stored_vals[slot-1];
                  slot--;
               end
               stored_vals[slot] = val;
               stored_cnt++;
            end
            restart_enum();
         end
         CMD_NEXT: begin
            if (stored_cnt == 0 || enum_done) begin
               res.status = 1'b1;
               no_seq_count++;
            end else begin
               if (seq_len_reg == 0) len = 1;
               else if (seq_len_reg > MAX_LENGTH_DEF) len = MAX_LENGTH_DEF;
               else len = int'(seq_len_reg);
               for (k = 0; k < len; k++) begin
                  slot = int'(slot_idx[k]);
                  if (slot >= stored_cnt) slot = stored_cnt - 1;
                  res.elem[k] = stored_vals[slot];
               end
               // find the rightmost position that can still step up
               p = -1;
               for (k = 0; k < len; k++) begin
                  if (int'(slot_idx[k]) + 1 < stored_cnt) p = k;
               end
               if (p >= 0) begin
                  nv = slot_idx[p] + 1'b1;
                  for (k = p; k < len; k++) slot_idx[k] = nv;
               end else begin
                  enum_done    = 1'b1;
                  res.is_final = 1'b1;
                  final_count++;
               end
            end
            expected_seqs = {expected_seqs, res};
         end
         default: ;
      endcase
   endfunction

   task automatic wait_drained();
      while (sent_count != queued_total || expected_seqs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : driver
      cmd_item_type item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_command(req_bus.command, req_bus.value);
            sent_count++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = pending_cmds.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.command <= item.command;
               req_bus.value   <= item.value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_kick) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : monitor
      result_type got, want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.elem[0]  = rsp_bus.elem_0;
            got.elem[1]  = rsp_bus.elem_1;
            got.elem[2]  = rsp_bus.elem_2;
            got.elem[3]  = rsp_bus.elem_3;
            got.elem[4]  = rsp_bus.elem_4;
            got.elem[5]  = rsp_bus.elem_5;
            got.elem[6]  = rsp_bus.elem_6;
            got.elem[7]  = rsp_bus.elem_7;
            got.is_final = rsp_bus.is_final;
            got.status   = rsp_bus.status;
            if (expected_seqs.size() == 0) begin
               $error("result transaction with no request pending: elem_0=%h status=%0b",
                      got.elem[0], got.status);
               err_count++;
            end else begin
               want = expected_seqs.pop_front();
               checked_count++;
               for (int k = 0; k < NUM_ELEMS; k++) begin
                  if (got.elem[k] !== want.elem[k]) begin
                     $error("elem_%0d: expected %h, actual %h", k, want.elem[k], got.elem[k]);
                     err_count++;
                  end
               end
               if (got.is_final !== want.is_final) begin
                  $error("is_final: expected %0b, actual %0b", want.is_final, got.is_final);
                  err_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0b, actual %0b", want.status, got.status);
                  err_count++;
               end
            end
         end
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("multiset_combination_generator_tb: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      logic [LEN_W-1:0]   phase_len [NUM_PHASES];
      logic [VALUE_W-1:0] last_val, val;
      int target, nload, nnext, k;
      phase_len = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd2, 4'd5, 4'd8};
      phase_len[6] = LEN_W'($urandom_range(15));
      last_val = '0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      hold_kick = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_CLEAR;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed opener at the reset length of one
      push_cmd(CMD_NEXT, 16'h1234);
      push_cmd(CMD_UNUSED, 16'hFFFF);
      push_cmd(CMD_LOAD, 16'hFFFF);
      push_cmd(CMD_LOAD, 16'h0000);
      push_cmd(CMD_LOAD, 16'h0000);
      push_cmd(CMD_LOAD, 16'h8000);
      for (k = 0; k < 3; k++) push_cmd(CMD_NEXT, 16'h0000);
      push_cmd(CMD_LOAD, 16'h7FFF);
      for (k = 0; k < 6; k++) push_cmd(CMD_NEXT, 16'hFFFF);
      for (k = 0; k < 4; k++) push_cmd(CMD_LOAD, 16'h0001 << k);
      push_cmd(CMD_NEXT, 16'h0000);
      push_cmd(CMD_CLEAR, 16'hFFFF);
      push_cmd(CMD_NEXT, 16'h0000);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         @(posedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= phase_len[p];
         seq_len_reg = phase_len[p];
         restart_enum();
         @(posedge clock);
         csr_wr_en <= 1'b0;
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 55; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 55; end
            default: begin send_idle_pct = 38; stall_pct = 38; end
         endcase
         target = useful_total + ITEMS_PER_PHASE;
         while (useful_total < target) begin
            if ($urandom_range(99) < 75) begin
               if ($urandom_range(3) != 0) begin
                  push_cmd(CMD_CLEAR, VALUE_W'($urandom_range(16'hFFFF)));
               end
               nload = $urandom_range(1) ? $urandom_range(3, 1) : $urandom_range(9, 1);
               for (k = 0; k < nload; k++) begin
                  case ($urandom_range(9))
                     0: val = '0;
                     1: val = '1;
                     2, 3: val = last_val;
                     default: val = VALUE_W'($urandom_range(16'hFFFF));
                  endcase
                  last_val = val;
                  push_cmd(CMD_LOAD, val);
               end
               nnext = $urandom_range(40, 1);
               for (k = 0; k < nnext; k++) begin
                  if ($urandom_range(19) == 0) begin
                     push_cmd(CMD_UNUSED, VALUE_W'($urandom_range(16'hFFFF)));
                  end
                  push_cmd(CMD_NEXT, VALUE_W'($urandom_range(16'hFFFF)));
               end
            end else begin
               push_cmd(CMD_W'($urandom_range(3)), VALUE_W'($urandom_range(16'hFFFF)));
            end
         end
         if (p == 4) begin
            // hold the result channel off while commands keep coming
            @(posedge clock);
            hold_kick <= 1'b1;
            @(posedge clock);
            hold_kick <= 1'b0;
         end
      end

      wait_drained();
      $display("%0d command transactions over a directed run and %0d random phases",
               sent_count, NUM_PHASES);
      $display("%0d sequences checked, %0d final, %0d with no sequence, %0d loads dropped",
               checked_count, final_count, no_seq_count, dropped_loads);
      if (err_count == 0) begin
         $display("multiset_combination_generator_tb: PASS");
      end else begin
         $display("multiset_combination_generator_tb: FAIL");
      end
      $finish;
   end

endmodule
